FILE: design/otgs_pkg.sv
// Shared types, constants and the 6x8 font table for the text glyph streamer.
`default_nettype none
package otgs_pkg;

  localparam int unsigned GLYPH_WIDTH    = 6;
  localparam int unsigned GLYPH_COUNT    = 96;
  localparam int unsigned BYTES_PER_CHAR = 3 + GLYPH_WIDTH;
  localparam int unsigned IDX_W          = $clog2(BYTES_PER_CHAR);
  localparam int unsigned GLYPH_W        = $clog2(GLYPH_COUNT);
  localparam int unsigned ROW_W          = 8 * GLYPH_WIDTH;

  localparam logic [7:0] FIRST_CODE  = 8'd32;
  localparam logic [7:0] PAGE_CMD    = 8'hB0;
  localparam logic [7:0] COL_HI_CMD  = 8'h10;
  localparam logic [7:0] COL_LO_CMD  = 8'h01;
  localparam logic [7:0] HI_MASK     = 8'hF0;
  localparam logic [7:0] LO_MASK     = 8'h0F;
  localparam logic [7:0] WRAP_RESET  = 8'd126;
  localparam logic [7:0] COL_STEP    = 8'd6;

  // Positions of the cursor set-up bytes within one character
  localparam logic [IDX_W-1:0] IDX_PAGE   = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_COL_HI = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_COL_LO = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(BYTES_PER_CHAR - 1);

  // One classified character as it travels from front to back
  typedef struct packed {
    logic [7:0]       page;
    logic [7:0]       column;
    logic [ROW_W-1:0] glyph_row;  // first font column in the top byte
    logic             bad;
  } char_t;

  // Six font columns of one glyph, first column in the top byte
  function automatic logic [ROW_W-1:0] font_row(input logic [GLYPH_W-1:0] glyph);
    logic [ROW_W-1:0] row;
    case (glyph)
      7'd0:  row = 48'h000000000000;
      7'd1:  row = 48'h0000002F0000;
      7'd2:  row = 48'h000007000700;
      7'd3:  row = 48'h00147F147F14;
      7'd4:  row = 48'h00242A7F2A12;
      7'd5:  row = 48'h006264081323;
      7'd6:  row = 48'h003649552250;
      7'd7:  row = 48'h000005030000;
      7'd8:  row = 48'h00001C224100;
      7'd9:  row = 48'h000041221C00;
      7'd10: row = 48'h0014083E0814;
      7'd11: row = 48'h0008083E0808;
      7'd12: row = 48'h000000A06000;
      7'd13: row = 48'h000808080808;
      7'd14: row = 48'h000060600000;
      7'd15: row = 48'h002010080402;
      7'd16: row = 48'h003E5149453E;
      7'd17: row = 48'h0000427F4000;
      7'd18: row = 48'h004261514946;
      7'd19: row = 48'h002141454B31;
      7'd20: row = 48'h001814127F10;
      7'd21: row = 48'h002745454539;
      7'd22: row = 48'h003C4A494930;
      7'd23: row = 48'h000171090503;
      7'd24: row = 48'h003649494936;
      7'd25: row = 48'h00064949291E;
      7'd26: row = 48'h000036360000;
      7'd27: row = 48'h000056360000;
      7'd28: row = 48'h000814224100;
      7'd29: row = 48'h001414141414;
      7'd30: row = 48'h000041221408;
      7'd31: row = 48'h000201510906;
      7'd32: row = 48'h00324959513E;
      7'd33: row = 48'h007C1211127C;
      7'd34: row = 48'h007F49494936;
      7'd35: row = 48'h003E41414122;
      7'd36: row = 48'h007F4141221C;
      7'd37: row = 48'h007F49494941;
      7'd38: row = 48'h007F09090901;
      7'd39: row = 48'h003E4149497A;
      7'd40: row = 48'h007F0808087F;
      7'd41: row = 48'h0000417F4100;
      7'd42: row = 48'h002040413F01;
      7'd43: row = 48'h007F08142241;
      7'd44: row = 48'h007F40404040;
      7'd45: row = 48'h007F020C027F;
      7'd46: row = 48'h007F0408107F;
      7'd47: row = 48'h003E4141413E;
      7'd48: row = 48'h007F09090906;
      7'd49: row = 48'h003E4151215E;
      7'd50: row = 48'h007F09192946;
      7'd51: row = 48'h004649494931;
      7'd52: row = 48'h0001017F0101;
      7'd53: row = 48'h003F4040403F;
      7'd54: row = 48'h001F2040201F;
      7'd55: row = 48'h003F4038403F;
      7'd56: row = 48'h006314081463;
      7'd57: row = 48'h000708700807;
      7'd58: row = 48'h006151494543;
      7'd59: row = 48'h00007F414100;
      7'd60: row = 48'h00552A552A55;
      7'd61: row = 48'h000041417F00;
      7'd62: row = 48'h000402010204;
      7'd63: row = 48'h004040404040;
      7'd64: row = 48'h000001020400;
      7'd65: row = 48'h002054545478;
      7'd66: row = 48'h007F48444438;
      7'd67: row = 48'h003844444420;
      7'd68: row = 48'h00384444487F;
      7'd69: row = 48'h003854545418;
      7'd70: row = 48'h00087E090102;
      7'd71: row = 48'h0018A4A4A47C;
      7'd72: row = 48'h007F08040478;
      7'd73: row = 48'h0000447D4000;
      7'd74: row = 48'h004080847D00;
      7'd75: row = 48'h007F10284400;
      7'd76: row = 48'h0000417F4000;
      7'd77: row = 48'h007C04180478;
      7'd78: row = 48'h007C08040478;
      7'd79: row = 48'h003844444438;
      7'd80: row = 48'h00FC24242418;
      7'd81: row = 48'h0018242418FC;
      7'd82: row = 48'h007C08040408;
      7'd83: row = 48'h004854545420;
      7'd84: row = 48'h00043F444020;
      7'd85: row = 48'h003C4040207C;
      7'd86: row = 48'h001C2040201C;
      7'd87: row = 48'h003C4030403C;
      7'd88: row = 48'h004428102844;
      7'd89: row = 48'h001CA0A0A07C;
      7'd90: row = 48'h004464544C44;
      7'd91: row = 48'h141414141414;
      default: row = '0;
    endcase
    return row;
  endfunction

endpackage
`default_nettype wire

FILE: design/oled_text_glyph_streamer.sv
// Top level of the OLED text glyph streamer: front, queue and byte sequencer.
//
// Usage: each request on the input channel (in_valid_i, in_stall_o) carries one
// character code plus an optional string start with a start column and page.
// For every character the block emits nine requests on the output channel
// (out_valid_o, out_stall_i): three cursor set-up command bytes (page, column
// high nibble, column low nibble), then six font data bytes; last_of_char_o
// marks the ninth. Codes outside 32..127 send the blank glyph with
// bad_character_o high on all nine bytes.
// The wrap column register is written through cfg_valid_i / cfg_data_i;
// cfg_ready_o is always high. Write it only while the block is idle.
// The first byte of a character passes through a queue entry and then the
// output register; the single-byte output register sets the throughput, and
// a two-entry queue lets the front accept characters while bytes drain.
// Reset clears the cursor to column 0, page 0, sets the wrap column to 126
// and empties the queue. When the receiver stalls, the output byte holds and
// the input stalls once the queue is full.
`default_nettype none
module oled_text_glyph_streamer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] character_i,
  input  wire logic       string_start_i,
  input  wire logic [7:0] start_column_i,
  input  wire logic [7:0] start_page_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      display_byte_o,
  output logic            is_command_o,
  output logic            last_of_char_o,
  output logic            bad_character_o
);

  logic            push, pop, full, empty;
  otgs_pkg::char_t push_data, head;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;

  otgs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .character_i    (character_i),
    .string_start_i (string_start_i),
    .start_column_i (start_column_i),
    .start_page_i   (start_page_i),
    .full_i         (full),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  otgs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (full),
    .empty_o     (empty),
    .head_o      (head)
  );

  otgs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .head_i          (head),
    .pop_o           (pop),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .display_byte_o  (display_byte_o),
    .is_command_o    (is_command_o),
    .last_of_char_o  (last_of_char_o),
    .bad_character_o (bad_character_o)
  );

endmodule
`default_nettype wire

FILE: design/otgs_front.sv
// Front end: holds the cursor and wrap limit, classifies each character.
`default_nettype none
module otgs_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_valid_i,
  input  wire logic [7:0]     cfg_data_i,
  input  wire logic           in_valid_i,
  input  wire logic [7:0]     character_i,
  input  wire logic           string_start_i,
  input  wire logic [7:0]     start_column_i,
  input  wire logic [7:0]     start_page_i,
  input  wire logic           full_i,
  output logic                push_o,
  output otgs_pkg::char_t     push_data_o
);

  logic [7:0] wrap_q;
  logic [7:0] col_q, col_d;
  logic [7:0] page_q, page_d;
  logic [7:0] col_sel, page_sel;
  logic       wrap;
  logic       bad;
  logic [7:0] code_off;
  logic [otgs_pkg::GLYPH_W-1:0] glyph;

  assign push_o = in_valid_i && !full_i;

  // Cursor after an optional string start and a line wrap
  always_comb begin
    col_sel  = string_start_i ? start_column_i : col_q;
    page_sel = string_start_i ? start_page_i   : page_q;
    wrap     = col_sel > wrap_q;
    page_d   = wrap ? page_sel + 8'd1 : page_sel;
    col_d    = wrap ? 8'd0 : col_sel;
  end

  // Out-of-range codes fall back to the blank glyph
  always_comb begin
    bad      = (character_i < otgs_pkg::FIRST_CODE) || character_i[7];
    code_off = character_i - otgs_pkg::FIRST_CODE;
    glyph    = bad ? '0 : code_off[otgs_pkg::GLYPH_W-1:0];
    push_data_o.page      = page_d;
    push_data_o.column    = col_d;
    push_data_o.glyph_row = otgs_pkg::font_row(glyph);
    push_data_o.bad       = bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= otgs_pkg::WRAP_RESET;
      col_q  <= '0;
      page_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        wrap_q <= cfg_data_i;
      end
      if (push_o) begin
        col_q  <= col_d + otgs_pkg::COL_STEP;
        page_q <= page_d;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/otgs_queue.sv
// Two-entry queue of classified characters between front and back.
`default_nettype none
module otgs_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire otgs_pkg::char_t push_data_i,
  input  wire logic           pop_i,
  output logic                full_o,
  output logic                empty_o,
  output otgs_pkg::char_t     head_o
);

  otgs_pkg::char_t mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign head_o  = mem_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/otgs_back.sv
// Back end: sequences nine display bytes per character into an output register.
`default_nettype none
module otgs_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           empty_i,
  input  wire otgs_pkg::char_t head_i,
  output logic                pop_o,
  input  wire logic           out_stall_i,
  output logic                out_valid_o,
  output logic [7:0]          display_byte_o,
  output logic                is_command_o,
  output logic                last_of_char_o,
  output logic                bad_character_o
);

  localparam int unsigned DATA_IDX_W = $clog2(otgs_pkg::GLYPH_WIDTH);

  logic [otgs_pkg::IDX_W-1:0] idx_q;
  logic                       out_valid_q;
  logic [7:0]                 byte_q;
  logic                       cmd_q, last_q, bad_q;
  logic                       advance;
  logic                       load;
  logic [7:0]                 byte_d;
  logic [otgs_pkg::IDX_W-1:0] data_idx_full;
  logic [DATA_IDX_W-1:0]      data_idx;
  logic [otgs_pkg::ROW_W-1:0] row_shifted;

  assign advance = !out_valid_q || !out_stall_i;
  assign load    = advance && !empty_i;
  assign pop_o   = load && (idx_q == otgs_pkg::IDX_LAST);

  // Pick the byte for the current position
  always_comb begin
    data_idx_full = idx_q - otgs_pkg::IDX_W'(3);
    data_idx      = data_idx_full[DATA_IDX_W-1:0];
    row_shifted   = head_i.glyph_row << (8 * data_idx);
    case (idx_q)
      otgs_pkg::IDX_PAGE:   byte_d = otgs_pkg::PAGE_CMD + head_i.page;
      otgs_pkg::IDX_COL_HI: byte_d = otgs_pkg::COL_HI_CMD
                                   | ((head_i.column & otgs_pkg::HI_MASK) >> 4);
      otgs_pkg::IDX_COL_LO: byte_d = otgs_pkg::COL_LO_CMD
                                   | (head_i.column & otgs_pkg::LO_MASK);
      default:              byte_d = row_shifted[otgs_pkg::ROW_W-1 -: 8];
    endcase
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      cmd_q  <= idx_q < otgs_pkg::IDX_W'(3);
      last_q <= idx_q == otgs_pkg::IDX_LAST;
      bad_q  <= head_i.bad;
    end
  end

  // Byte position and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= !empty_i;
      end
      if (load) begin
        idx_q <= (idx_q == otgs_pkg::IDX_LAST) ? '0 : idx_q + otgs_pkg::IDX_W'(1);
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign display_byte_o  = byte_q;
  assign is_command_o    = cmd_q;
  assign last_of_char_o  = last_q;
  assign bad_character_o = bad_q;

endmodule
`default_nettype wire

FILE: tb/sv/oled_text_glyph_streamer_test.sv
// Self-checking testbench for the OLED text glyph streamer: cursor set-up and font bytes.
`default_nettype none
module oled_text_glyph_streamer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CLK_HALF       = 10;
  localparam int         RESET_CYCLES   = 12;
  localparam int         SETTLE_CYCLES  = 4;
  localparam int         DRAIN_CYCLES   = 20;
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         MAX_WAIT       = 17;
  localparam int         PRINT_CAP      = 40;
  localparam int         GLYPH_COLS     = 6;
  localparam int         GLYPHS         = 96;
  localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
  localparam logic [7:0] LAST_PRINTABLE  = 8'd127;
  localparam logic [7:0] PAGE_BASE       = 8'hB0;
  localparam logic [7:0] COL_HI_BASE     = 8'h10;
  localparam logic [7:0] COL_LO_BASE     = 8'h01;
  localparam logic [7:0] LO_NIBBLE       = 8'h0F;
  localparam logic [7:0] WRAP_AT_RESET   = 8'd126;

  // 6x8 font, one glyph per entry, first font column in the top byte.
  // The last four glyphs (codes 124..127) are blank.
  localparam logic [0:GLYPHS-1][47:0] FONT_ROWS = {
    48'h000000000000, 48'h0000002F0000, 48'h000007000700, 48'h00147F147F14,
    48'h00242A7F2A12, 48'h006264081323, 48'h003649552250, 48'h000005030000,
    48'h00001C224100, 48'h000041221C00, 48'h0014083E0814, 48'h0008083E0808,
    48'h000000A06000, 48'h000808080808, 48'h000060600000, 48'h002010080402,
    48'h003E5149453E, 48'h0000427F4000, 48'h004261514946, 48'h002141454B31,
    48'h001814127F10, 48'h002745454539, 48'h003C4A494930, 48'h000171090503,
    48'h003649494936, 48'h00064949291E, 48'h000036360000, 48'h000056360000,
    48'h000814224100, 48'h001414141414, 48'h000041221408, 48'h000201510906,
    48'h00324959513E, 48'h007C1211127C, 48'h007F49494936, 48'h003E41414122,
    48'h007F4141221C, 48'h007F49494941, 48'h007F09090901, 48'h003E4149497A,
    48'h007F0808087F, 48'h0000417F4100, 48'h002040413F01, 48'h007F08142241,
    48'h007F40404040, 48'h007F020C027F, 48'h007F0408107F, 48'h003E4141413E,
    48'h007F09090906, 48'h003E4151215E, 48'h007F09192946, 48'h004649494931,
    48'h0001017F0101, 48'h003F4040403F, 48'h001F2040201F, 48'h003F4038403F,
    48'h006314081463, 48'h000708700807, 48'h006151494543, 48'h00007F414100,
    48'h00552A552A55, 48'h000041417F00, 48'h000402010204, 48'h004040404040,
    48'h000001020400, 48'h002054545478, 48'h007F48444438, 48'h003844444420,
    48'h00384444487F, 48'h003854545418, 48'h00087E090102, 48'h0018A4A4A47C,
    48'h007F08040478, 48'h0000447D4000, 48'h004080847D00, 48'h007F10284400,
    48'h0000417F4000, 48'h007C04180478, 48'h007C08040478, 48'h003844444438,
    48'h00FC24242418, 48'h0018242418FC, 48'h007C08040408, 48'h004854545420,
    48'h00043F444020, 48'h003C4040207C, 48'h001C2040201C, 48'h003C4030403C,
    48'h004428102844, 48'h001CA0A0A07C, 48'h004464544C44, 48'h141414141414,
    48'h000000000000, 48'h000000000000, 48'h000000000000, 48'h000000000000
  };

  typedef struct packed {
    logic [7:0] character;
    logic       string_start;
    logic [7:0] start_column;
    logic [7:0] start_page;
  } text_req_t;

  typedef struct packed {
    logic [7:0] display_byte;
    logic       is_command;
    logic       last_of_char;
    logic       bad_character;
  } glyph_byte_t;

  // DUT inputs, all known from time zero
  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       cfg_valid_i    = 1'b0;
  logic [7:0] cfg_data_i     = 8'd0;
  logic       in_valid_i     = 1'b0;
  logic [7:0] character_i    = 8'd0;
  logic       string_start_i = 1'b0;
  logic [7:0] start_column_i = 8'd0;
  logic [7:0] start_page_i   = 8'd0;
  logic       out_stall_i    = 1'b0;

  logic       cfg_ready_o;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] display_byte_o;
  logic       is_command_o;
  logic       last_of_char_o;
  logic       bad_character_o;

  oled_text_glyph_streamer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .character_i    (character_i),
    .string_start_i (string_start_i),
    .start_column_i (start_column_i),
    .start_page_i   (start_page_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .display_byte_o (display_byte_o),
    .is_command_o   (is_command_o),
    .last_of_char_o (last_of_char_o),
    .bad_character_o(bad_character_o)
  );

  // Testbench state
  text_req_t   pending_chars[$];
  glyph_byte_t glyph_bytes_q[$];
  logic [7:0]  wrap_setting = WRAP_AT_RESET;
  logic [7:0]  cursor_col   = 8'd0;
  logic [7:0]  cursor_pg    = 8'd0;
  int          error_count  = 0;
  int          idle_cycles  = 0;

  text_req_t   cur_req;
  bit          sending    = 1'b0;
  int          send_gap   = 0;
  int          send_calm  = 0;
  int          recv_wait  = 0;
  int          recv_calm  = 0;
  glyph_byte_t got_byte;
  glyph_byte_t exp_byte;

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_CAP) $display("MISMATCH: %s", msg);
    error_count++;
  endtask

  // Wait before the next request: random, with occasional runs of back-to-back
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) calm_left = $urandom_range(8, 30);
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Cursor update and the nine bytes one character produces
  task automatic predict_glyph(input text_req_t r);
    logic       bad;
    logic [6:0] glyph;
    logic [7:0] col_byte;
    if (r.string_start) begin
      cursor_col = r.start_column;
      cursor_pg  = r.start_page;
    end
    if (cursor_col > wrap_setting) begin
      cursor_col = 8'd0;
      cursor_pg  = cursor_pg + 8'd1;
    end
    bad   = (r.character < FIRST_PRINTABLE) || (r.character > LAST_PRINTABLE);
    glyph = bad ? 7'd0 : 7'(r.character - FIRST_PRINTABLE);
    glyph_bytes_q.push_back('{PAGE_BASE + cursor_pg, 1'b1, 1'b0, bad});
    glyph_bytes_q.push_back('{COL_HI_BASE | (cursor_col >> 4), 1'b1, 1'b0, bad});
    glyph_bytes_q.push_back('{COL_LO_BASE | (cursor_col & LO_NIBBLE), 1'b1, 1'b0, bad});
    for (int i = 0; i < GLYPH_COLS; i++) begin
      col_byte = FONT_ROWS[glyph][47 - 8 * i -: 8];
      glyph_bytes_q.push_back('{col_byte, 1'b0, i == GLYPH_COLS - 1, bad});
    end
    cursor_col = cursor_col + 8'(GLYPH_COLS);
  endtask

  // Driver: one character request at a time from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sending    = 1'b0;
      send_gap   = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_glyph(cur_req);
        sending  = 1'b0;
        send_gap = draw_wait(send_calm);
      end
      if (!sending) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_chars.size() != 0) begin
          cur_req = pending_chars.pop_front();
          sending = 1'b1;
        end
      end
      in_valid_i     <= sending;
      character_i    <= cur_req.character;
      string_start_i <= cur_req.string_start;
      start_column_i <= cur_req.start_column;
      start_page_i   <= cur_req.start_page;
    end
  end

  // Monitor: check each output byte against the oldest expectation, random stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_wait   = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got_byte = {display_byte_o, is_command_o, last_of_char_o, bad_character_o};
        if (glyph_bytes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %h", got_byte.display_byte));
        end else begin
          exp_byte = glyph_bytes_q.pop_front();
          if (got_byte.display_byte !== exp_byte.display_byte ||
              got_byte.is_command !== exp_byte.is_command ||
              got_byte.last_of_char !== exp_byte.last_of_char ||
              got_byte.bad_character !== exp_byte.bad_character)
            report_mismatch($sformatf(
              "byte %h/%h cmd %b/%b last %b/%b bad %b/%b (got/exp)",
              got_byte.display_byte, exp_byte.display_byte,
              got_byte.is_command, exp_byte.is_command,
              got_byte.last_of_char, exp_byte.last_of_char,
              got_byte.bad_character, exp_byte.bad_character));
        end
        recv_wait = draw_wait(recv_calm);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_stall_i <= (recv_wait > 0);
    end
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("oled_text_glyph_streamer_test: done, errors");
        $finish;
      end
    end
  end

  function automatic text_req_t mk_req(input logic [7:0] ch, input logic st,
                                       input logic [7:0] col, input logic [7:0] pg);
    text_req_t r;
    r.character    = ch;
    r.string_start = st;
    r.start_column = col;
    r.start_page   = pg;
    return r;
  endfunction

  // Mostly printable, sometimes any code
  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 11) == 0) return 8'($urandom);
    return 8'($urandom_range(FIRST_PRINTABLE, LAST_PRINTABLE));
  endfunction

  // Start columns cluster near the wrap point half the time
  function automatic logic [7:0] pick_column();
    if ($urandom_range(0, 1) == 0) return wrap_setting - 8'($urandom_range(0, 12));
    return 8'($urandom);
  endfunction

  // Strings with random content, with some stray requests mixed in
  task automatic push_random_text(input int count);
    int n;
    int len;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_chars.push_back(mk_req(8'($urandom), 1'($urandom), 8'($urandom),
                                       8'($urandom)));
        n++;
      end else begin
        pending_chars.push_back(mk_req(pick_char(), 1'b1, pick_column(), 8'($urandom)));
        n++;
        len = $urandom_range(0, 12);
        repeat (len) begin
          pending_chars.push_back(mk_req(pick_char(), 1'b0, 8'($urandom), 8'($urandom)));
          n++;
        end
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_chars.size() != 0 || in_valid_i || glyph_bytes_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_wrap(input logic [7:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    wrap_setting = value;
  endtask

  // Stimulus sequence
  initial begin
    logic [7:0] wrap_plan[6];
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset wrap column: glyph set edges, bad codes, wrap and overflow
    @(negedge clk_i);
    pending_chars.push_back(mk_req(8'd65, 1'b0, 8'd0, 8'd0));
    pending_chars.push_back(mk_req(8'd32, 1'b0, 8'd0, 8'd0));
    pending_chars.push_back(mk_req(8'd127, 1'b0, 8'd0, 8'd0));
    pending_chars.push_back(mk_req(8'd126, 1'b0, 8'd0, 8'd0));
    pending_chars.push_back(mk_req(8'd31, 1'b0, 8'd0, 8'd0));
    pending_chars.push_back(mk_req(8'd0, 1'b0, 8'd0, 8'd0));
    pending_chars.push_back(mk_req(8'd128, 1'b0, 8'd0, 8'd0));
    pending_chars.push_back(mk_req(8'd255, 1'b0, 8'd0, 8'd0));
    pending_chars.push_back(mk_req(8'd66, 1'b1, 8'd120, 8'd7));
    pending_chars.push_back(mk_req(8'd67, 1'b0, 8'd0, 8'd0));
    pending_chars.push_back(mk_req(8'd68, 1'b0, 8'd0, 8'd0));
    // page wraps past 255, then page byte overflows past 0xFF
    pending_chars.push_back(mk_req(8'd126, 1'b1, 8'd255, 8'd255));
    pending_chars.push_back(mk_req(8'd122, 1'b1, 8'd0, 8'h50));
    wait_idle();

    // Widest wrap column: column arithmetic wraps past 255
    write_wrap(8'd255);
    pending_chars.push_back(mk_req(8'd97, 1'b1, 8'd252, 8'hFF));
    pending_chars.push_back(mk_req(8'd48, 1'b0, 8'd0, 8'd0));
    pending_chars.push_back(mk_req(8'd57, 1'b1, 8'd255, 8'd0));
    pending_chars.push_back(mk_req(8'd77, 1'b0, 8'd0, 8'd0));
    wait_idle();

    // Narrowest wrap column: every nonzero column wraps
    write_wrap(8'd0);
    pending_chars.push_back(mk_req(8'd120, 1'b1, 8'd0, 8'd255));
    pending_chars.push_back(mk_req(8'd121, 1'b0, 8'd0, 8'd0));
    pending_chars.push_back(mk_req(8'd32, 1'b1, 8'd1, 8'd0));
    wait_idle();

    // Random text over several wrap settings
    wrap_plan = '{8'($urandom), WRAP_AT_RESET, 8'd255, 8'd0, 8'($urandom), 8'($urandom)};
    foreach (wrap_plan[p]) begin
      write_wrap(wrap_plan[p]);
      if (p == 1) begin
        // sender holds off until every byte has drained, then resumes
        push_random_text(25);
        wait_idle();
        @(negedge clk_i);
        push_random_text(25);
      end else begin
        push_random_text(50);
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("oled_text_glyph_streamer_test: done, clean");
    end else begin
      $display("oled_text_glyph_streamer_test: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
